FILE: src/kdsw_pkg.sv
// Package for the keyed square digraph swap unit: codes, constants, types
// and the character helper functions shared by controller, datapath and top.
// Depends on nothing.
`default_nettype none

package kdsw_pkg;

  // Function codes carried with every input word.
  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_KEY    = 3'd1;
  localparam logic [2:0] FN_FINISH = 3'd2;
  localparam logic [2:0] FN_TEXT   = 3'd3;
  localparam logic [2:0] FN_END    = 3'd4;

  // Square geometry.
  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int LETTERS = 26;

  // Character constants.
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LZ   = 8'h7A;
  localparam logic [7:0] CHAR_I    = 8'h49;
  localparam logic [7:0] CHAR_J    = 8'h4A;
  localparam logic [7:0] CASE_OFS  = 8'd32;

  // Letter indexes (A is zero).
  localparam logic [4:0] IDX_I     = 5'd8;
  localparam logic [4:0] IDX_J     = 5'd9;
  localparam logic [4:0] IDX_LAST  = 5'(LETTERS - 1);
  localparam logic [4:0] FILL_FULL = 5'(CELLS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOOKUP,
    ST_OUT_A,
    ST_OUT_B,
    ST_OUT_RAW
  } state_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_RAW
  } out_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     walk;
    logic     lookup;
    out_sel_t sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic held_valid;
    logic walk_last;
  } stat_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } rc_t;

  // Uppercase a-z only, then fold J onto I.
  function automatic logic [7:0] norm_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LA && c <= CHAR_LZ) begin
      r = c - CASE_OFS;
    end
    if (r == CHAR_J) begin
      r = CHAR_I;
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CHAR_A) && (c <= CHAR_Z);
  endfunction

  // Letter index of an uppercase letter; zero for anything else.
  function automatic logic [4:0] letter_index(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_A;
    return is_letter(c) ? d[4:0] : 5'd0;
  endfunction

  function automatic logic [7:0] letter_char(input logic [4:0] v);
    return CHAR_A + {3'b000, v};
  endfunction

  // Split a square position (0 to 24) into row and column.
  function automatic rc_t split_pos(input logic [4:0] p);
    rc_t        r;
    logic [4:0] rem;
    if (p >= 5'd20) begin
      r.row = 3'd4;
      rem   = p - 5'd20;
    end else if (p >= 5'd15) begin
      r.row = 3'd3;
      rem   = p - 5'd15;
    end else if (p >= 5'd10) begin
      r.row = 3'd2;
      rem   = p - 5'd10;
    end else if (p >= 5'd5) begin
      r.row = 3'd1;
      rem   = p - 5'd5;
    end else begin
      r.row = 3'd0;
      rem   = p;
    end
    r.col = rem[2:0];
    return r;
  endfunction

  // Position of (row, col): row * 5 + col.
  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

`default_nettype wire

FILE: src/kdsw_in_if.sv
// Input channel of the keyed square digraph swap unit: valid, ready and
// the function code with its byte. Depends on nothing.
`default_nettype none

interface kdsw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] in_char;

  modport source (output valid, output func, output in_char, input ready);
  modport sink (input valid, input func, input in_char, output ready);
endinterface

`default_nettype wire

FILE: src/kdsw_out_if.sv
// Result channel of the keyed square digraph swap unit: valid, ready, the
// output byte and the last flag. Depends on nothing.
`default_nettype none

interface kdsw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

FILE: src/keyed_square_digraph_swap_unit.sv
// Keyed square digraph swap unit. Clear, key, first text byte and empty end words
// give no result; finish key walks the alphabet in the walk state; a raw end byte
// shows in the cycle after acceptance. A second text byte gives its first result
// after the position and corner reads, its second in the cycle after the first is taken.
// Throughput: one word per cycle for words with no result other than finish key;
// otherwise the next word waits until all results are taken. Reset (synchronous) empties the square.
`default_nettype none

module keyed_square_digraph_swap_unit import kdsw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  kdsw_in_if.sink         in_bus,
  kdsw_out_if.source      out_bus
);

  // The controller owns the handshakes and sequencing; the datapath holds
  // the square, its inverse map of letter positions and the result bytes.
  // A text pair goes through two memory reads: first the positions of both
  // letters, then the two opposite corners of their rectangle.
  cmd_t  cmd;
  stat_t stat;

  kdsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_func   (in_bus.func),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_last  (out_bus.last),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kdsw_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_func  (in_bus.func),
    .in_char  (in_bus.in_char),
    .cmd      (cmd),
    .stat     (stat),
    .out_char (out_bus.out_char)
  );

`ifndef NO_ASSERTIONS
  // The block never offers a result while it takes a new word.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !in_bus.ready)
    else $error("input taken while a result is pending");

  // The first byte of a pair is always followed by the closing one.
  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready && !out_bus.last) |=> (out_bus.valid && out_bus.last))
    else $error("pair result missing its second byte");

  // A lone text byte is held for the next one.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.func == FN_TEXT && !stat.held_valid)
      |=> stat.held_valid)
    else $error("text byte not held");

  // End of text with a held byte gives a single final result.
  a_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.func == FN_END && stat.held_valid)
      |=> (out_bus.valid && out_bus.last))
    else $error("held byte not flushed at end of text");
`endif

endmodule

`default_nettype wire

FILE: src/kdsw_ctrl.sv
// Controller state machine of the keyed square digraph swap unit.
// Depends on kdsw_pkg.
`default_nettype none

module kdsw_ctrl import kdsw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_func,
  output logic       in_ready,
  output logic       out_valid,
  output logic       out_last,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_last   = 1'b0;
    cmd.accept = 1'b0;
    cmd.walk   = 1'b0;
    cmd.lookup = 1'b0;
    cmd.sel    = SEL_A;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (in_func == FN_FINISH) begin
            state_nxt = ST_WALK;
          end else if (in_func == FN_TEXT && stat.held_valid) begin
            state_nxt = ST_LOOKUP;
          end else if (in_func == FN_END && stat.held_valid) begin
            state_nxt = ST_OUT_RAW;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_OUT_A;
      end
      ST_OUT_A: begin
        out_valid = 1'b1;
        cmd.sel   = SEL_A;
        if (out_ready) begin
          state_nxt = ST_OUT_B;
        end
      end
      ST_OUT_B: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        cmd.sel   = SEL_B;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT_RAW: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        cmd.sel   = SEL_RAW;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/kdsw_dp.sv
// Datapath of the keyed square digraph swap unit: square and letter
// position memories, letter marks, held byte and result registers.
// Depends on kdsw_pkg.
`default_nettype none

module kdsw_dp import kdsw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] in_func,
  input  logic [7:0] in_char,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic [7:0] out_char
);

  // Square entries hold letter indexes; the position memory is its inverse.
  logic [4:0]  sq_mem  [0:CELLS-1];
  logic [4:0]  pos_mem [0:LETTERS-1];

  logic [4:0]  fill_r;
  logic [25:0] present_r;
  logic [7:0]  held_char_r;
  logic        held_valid_r;
  logic [4:0]  walk_r;

  logic [7:0]  a_r;
  logic [7:0]  b_r;
  logic        hit_r;
  logic [7:0]  raw_r;
  logic [4:0]  pos1_r;
  logic [4:0]  pos2_r;
  logic [4:0]  sq1_r;
  logic [4:0]  sq2_r;

  logic [7:0]  key_n;
  logic [7:0]  a_n;
  logic [7:0]  b_n;
  logic [4:0]  ia;
  logic [4:0]  ib;
  logic        hit_nxt;
  logic [4:0]  walk_idx;
  logic        add_req;
  logic [4:0]  add_idx;
  logic        add_en;
  logic        do_pair;
  logic        do_hold;
  logic        do_raw;
  logic        do_clear;
  rc_t         rc1;
  rc_t         rc2;

  assign key_n   = norm_char(in_char);
  assign a_n     = norm_char(held_char_r);
  assign b_n     = norm_char(in_char);
  assign ia      = letter_index(a_n);
  assign ib      = letter_index(b_n);
  assign hit_nxt = is_letter(a_n) && present_r[ia] && is_letter(b_n) && present_r[ib];

  assign walk_idx = (walk_r == IDX_J) ? IDX_I : walk_r;

  assign do_clear = cmd.accept && (in_func == FN_CLEAR);
  assign do_hold  = cmd.accept && (in_func == FN_TEXT) && !held_valid_r;
  assign do_pair  = cmd.accept && (in_func == FN_TEXT) && held_valid_r;
  assign do_raw   = cmd.accept && (in_func == FN_END) && held_valid_r;

  always_comb begin
    add_req = 1'b0;
    add_idx = walk_idx;
    if (cmd.walk) begin
      add_req = 1'b1;
    end else if (cmd.accept && in_func == FN_KEY) begin
      add_req = is_letter(key_n);
      add_idx = letter_index(key_n);
    end
  end

  assign add_en = add_req && (fill_r < FILL_FULL) && !present_r[add_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      present_r    <= '0;
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
      walk_r       <= '0;
    end else begin
      if (do_clear) begin
        fill_r       <= '0;
        present_r    <= '0;
        held_char_r  <= '0;
        held_valid_r <= 1'b0;
      end else begin
        if (add_en) begin
          fill_r             <= fill_r + 5'd1;
          present_r[add_idx] <= 1'b1;
        end
        if (do_hold) begin
          held_char_r  <= in_char;
          held_valid_r <= 1'b1;
        end else if (do_pair || do_raw) begin
          held_char_r  <= '0;
          held_valid_r <= 1'b0;
        end
      end
      if (cmd.accept && in_func == FN_FINISH) begin
        walk_r <= '0;
      end else if (cmd.walk) begin
        walk_r <= walk_r + 5'd1;
      end
    end
  end

  // Memory writes on append.
  always_ff @(posedge clk) begin
    if (add_en) begin
      sq_mem[fill_r]   <= add_idx;
      pos_mem[add_idx] <= fill_r;
    end
  end

  // Pair capture and position reads.
  always_ff @(posedge clk) begin
    if (do_pair) begin
      a_r    <= a_n;
      b_r    <= b_n;
      hit_r  <= hit_nxt;
      pos1_r <= pos_mem[ia];
      pos2_r <= pos_mem[ib];
    end
    if (do_raw) begin
      raw_r <= held_char_r;
    end
  end

  assign rc1 = split_pos(pos1_r);
  assign rc2 = split_pos(pos2_r);

  // Opposite corner reads.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      sq1_r <= sq_mem[cell_index(rc1.row, rc2.col)];
      sq2_r <= sq_mem[cell_index(rc2.row, rc1.col)];
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_A:   out_char = hit_r ? letter_char(sq1_r) : a_r;
      SEL_B:   out_char = hit_r ? letter_char(sq2_r) : b_r;
      SEL_RAW: out_char = raw_r;
      default: out_char = raw_r;
    endcase
  end

  assign stat.held_valid = held_valid_r;
  assign stat.walk_last  = (walk_r == IDX_LAST);

endmodule

`default_nettype wire
